[hw/rtl/fys_pkg.sv]
// shared types and constants for the fisher-yates shuffle engine
// no dependencies; used by fys_mod_unit and fisher_yates_shuffle_engine

package fys_pkg;

    localparam int RAND_WIDTH = 31;
    localparam int ELEM_WIDTH = 16;
    localparam int POS_WIDTH  = 6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // request to the modulo unit
    typedef struct packed {
        logic                  start;
        logic [RAND_WIDTH-1:0] dividend;
    } mod_req_t;

endpackage

[hw/rtl/fys_mod_unit.sv]
// bit-serial restoring modulo unit: one dividend bit per cycle
// depends on fys_pkg (mod_req_t, RAND_WIDTH)

module fys_mod_unit #(
    parameter int CW = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fys_pkg::mod_req_t        req,
    input  logic [CW-1:0]            divisor,
    output logic                     done,
    output logic [CW-1:0]            remainder
);

    localparam int RW = fys_pkg::RAND_WIDTH;
    localparam int NW = $clog2(RW + 1);

    logic [RW-1:0] dvd_reg, dvd_next;
    logic [CW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW:0]   trial;
    logic [CW:0]   diff;

    assign trial = {rem_reg, dvd_reg[RW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = req.dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = NW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RW-2:0], 1'b0};
            // restoring step: keep the difference only when it does not go negative
            if (trial >= {1'b0, dvs_reg})
                rem_next = diff[CW-1:0];
            else
                rem_next = trial[CW-1:0];
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/fys_store.sv]
// tag store: one write port, one read port with registered read data
// no dependencies

module fys_store #(
    parameter int DEPTH     = 64,
    parameter int TAG_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [TAG_WIDTH-1:0]     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [TAG_WIDTH-1:0]     rdata
);

    logic [TAG_WIDTH-1:0] mem [DEPTH];
    logic [TAG_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fisher_yates_shuffle_engine.sv]
// top level of the fisher-yates shuffle engine: sequencer, list state, output register
// depends on fys_pkg, fys_mod_unit and fys_store

// A load word (tuser 0) appends its tag while the store has room; tlast closes the list.
// A step word (tuser 1) on a closed, unfinished list is accepted, then waits in the
// modulo stage (bit-serial iterations that reduce the random word by the remaining
// count, then the remainder is taken), passes RD_I, RD_J, WR_I and WR_J to read and
// swap the two store entries through the single read port, and in S_OUT hands the
// placed tag to the output register. tready stays low for the whole step, and longer
// while the output register is still held by the receiver. A step with nothing to
// place is accepted and yields no word. The store needs no clearing pass after reset.

module fisher_yates_shuffle_engine #(
    parameter int DEPTH     = 64,
    parameter int TAG_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // element[15:0], random_word[46:16], zero pad
    input  logic        s_tlast,   // last_element
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // placed_element[15:0], position[21:16], zero pad
    output logic        m_tlast    // last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = fys_pkg::ELEM_WIDTH;
    localparam int PW = fys_pkg::POS_WIDTH;
    localparam int RW = fys_pkg::RAND_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_RD_I = 3'd2;
    localparam logic [2:0] S_RD_J = 3'd3;
    localparam logic [2:0] S_WR_I = 3'd4;
    localparam logic [2:0] S_WR_J = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        step_reg, step_next;
    logic                 closed_reg, closed_next;
    logic [AW-1:0]        j_reg;
    logic [TAG_WIDTH-1:0] tag_i_reg;
    logic [TAG_WIDTH-1:0] tag_j_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [EW-1:0]        out_elem_reg;
    logic [PW-1:0]        out_pos_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 is_load;
    logic                 can_step;
    logic [CW-1:0]        base_count;
    logic [TAG_WIDTH-1:0] load_tag;
    logic [CW-1:0]        j_full;
    logic [PW-1:0]        pos_val;
    logic                 last_val;
    logic [EW-1:0]        placed_val;
    logic                 out_load;

    fys_pkg::mod_req_t    mod_req;
    logic                 mod_done;
    logic [CW-1:0]        mod_rem;

    logic                 st_we;
    logic [AW-1:0]        st_waddr;
    logic [TAG_WIDTH-1:0] st_wdata;
    logic [AW-1:0]        st_raddr;
    logic [TAG_WIDTH-1:0] st_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_load  = (s_tuser == fys_pkg::OP_LOAD);
    assign can_step = closed_reg && (step_reg < count_reg);

    // a load onto a closed list starts over at entry 0
    assign base_count = closed_reg ? '0 : count_reg;

    logic [TAG_WIDTH+EW-1:0] load_ext;
    assign load_ext = {{TAG_WIDTH{1'b0}}, s_tdata[EW-1:0]};
    assign load_tag = load_ext[TAG_WIDTH-1:0];

    logic [EW+TAG_WIDTH-1:0] placed_ext;
    assign placed_ext = {{EW{1'b0}}, tag_j_reg};
    assign placed_val = placed_ext[EW-1:0];

    logic [CW+PW-1:0] pos_ext;
    assign pos_ext  = {{PW{1'b0}}, step_reg};
    assign pos_val  = pos_ext[PW-1:0];
    assign last_val = (({1'b0, step_reg} + (CW+1)'(1)) == {1'b0, count_reg});

    assign j_full = step_reg + mod_rem;

    assign mod_req.start    = accept && !is_load && can_step;
    assign mod_req.dividend = s_tdata[EW+RW-1:EW];

    fys_mod_unit #(
        .CW (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .divisor   (count_reg - step_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    fys_store #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = base_count[AW-1:0];
        st_wdata = load_tag;
        st_raddr = step_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                st_we = accept && is_load && (base_count < CW'(DEPTH));
            end
            S_RD_J:
            begin
                st_raddr = j_reg;
            end
            S_WR_I:
            begin
                st_we    = 1'b1;
                st_waddr = step_reg[AW-1:0];
                st_wdata = st_rdata;
            end
            S_WR_J:
            begin
                st_we    = 1'b1;
                st_waddr = j_reg;
                st_wdata = tag_i_reg;
            end
            default:
            begin
                st_we = 1'b0;
            end
        endcase
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        closed_next    = closed_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        if (closed_reg)
                            step_next = '0;
                        count_next = base_count;
                        if (base_count < CW'(DEPTH))
                            count_next = base_count + CW'(1);
                        closed_next = s_tlast;
                    end
                    else if (can_step)
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                    state_next = S_RD_I;
            end
            S_RD_I: state_next = S_RD_J;
            S_RD_J: state_next = S_WR_I;
            S_WR_I: state_next = S_WR_J;
            S_WR_J: state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    step_next      = step_reg + CW'(1);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mod_done)
            j_reg <= j_full[AW-1:0];
        if (state_reg == S_RD_J)
            tag_i_reg <= st_rdata;
        // entry j lands at position i: that is the placed tag
        if (state_reg == S_WR_I)
            tag_j_reg <= st_rdata;
        if (out_load)
        begin
            out_elem_reg <= placed_val;
            out_pos_reg  <= pos_val;
            out_last_reg <= last_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_elem_reg};
    assign m_tlast  = out_last_reg;

endmodule
